// File: src/irp_pkg.sv
// Shared constants for the pool-adjacent-violators isotonic regression core.
// Holds field widths and sequencer state codes; no dependencies.
package irp_pkg;

  localparam int KEY_W    = 32;
  localparam int SAMPLE_W = 32;
  localparam int STATE_W  = 4;

  // Sequencer states
  localparam logic [STATE_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [STATE_W-1:0] ST_RD    = 4'd1;
  localparam logic [STATE_W-1:0] ST_CMP   = 4'd2;
  localparam logic [STATE_W-1:0] ST_DEC   = 4'd3;
  localparam logic [STATE_W-1:0] ST_FLUSH = 4'd4;
  localparam logic [STATE_W-1:0] ST_BRD   = 4'd5;
  localparam logic [STATE_W-1:0] ST_BLD   = 4'd6;
  localparam logic [STATE_W-1:0] ST_DIV   = 4'd7;
  localparam logic [STATE_W-1:0] ST_KRD   = 4'd8;
  localparam logic [STATE_W-1:0] ST_OUT   = 4'd9;

endpackage

// File: src/irp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module irp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/isotonic_regression_pava_core.sv
// Top level of the streaming pool-adjacent-violators isotonic regression core.
// Depends on irp_pkg and irp_ram.
//
// Points (key, sample) are taken one request at a time. Each point is pushed as
// a block; the top block is held in registers and the blocks beneath it in a
// block RAM. Each comparison with the block beneath is a RAM read, a registered
// cross-multiply, then compare and pool. The first point of a run needs no
// comparison; a later point compares again after each merge while blocks
// remain beneath, and merges average under one per point. On the final
// request the flush state writes the top block back to the RAM, then the
// stored points are emitted in order: each block is read and loaded, its
// mean is found by restoring division, then each point takes a key RAM read
// and an output load, the load waiting while the output side is stalled.
// Points beyond DEPTH are dropped and flagged as truncated. No clearing pass
// is needed after reset.
module isotonic_regression_pava_core
  import irp_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                point_valid,
  output logic                point_stall,
  input  logic signed [31:0]  key,
  input  logic signed [31:0]  sample,
  input  logic                final_req,
  output logic                result_valid,
  input  logic                result_stall,
  output logic signed [31:0]  key_out,
  output logic signed [31:0]  fitted,
  output logic                run_end,
  output logic                truncated
);

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + PW;
  localparam int BLK_W = SUM_W + CW + PW;
  localparam int PRD_W = SUM_W + CW + 1;
  localparam int IT_W  = $clog2(SUM_W + 1);

  logic [STATE_W-1:0] state;
  logic [CW-1:0]      point_count;
  logic [CW-1:0]      stack_top;
  logic               overflowed;
  logic               final_pend;

  // Top-of-stack block in registers
  logic signed [SUM_W-1:0] top_sum;
  logic [CW-1:0]           top_cnt;
  logic [PW-1:0]           top_start;

  // Block RAM interface
  logic             blk_wr_en;
  logic [PW-1:0]    blk_wr_addr;
  logic [BLK_W-1:0] blk_wr_data;
  logic             blk_rd_en;
  logic [PW-1:0]    blk_rd_addr;
  logic [BLK_W-1:0] blk_rd_data;

  logic signed [SUM_W-1:0] bel_sum;
  logic [CW-1:0]           bel_cnt;
  logic [PW-1:0]           bel_start;

  // Key RAM interface
  logic             key_wr_en;
  logic [PW-1:0]    key_rd_addr;
  logic [KEY_W-1:0] key_rd_data;

  // Cross products
  logic signed [PRD_W-1:0] lhs;
  logic signed [PRD_W-1:0] rhs;

  // Divider and emission
  logic [PW-1:0]    blk_idx;
  logic [SUM_W-1:0] dvd;
  logic [CW:0]      rem;
  logic [CW-1:0]    dvs;
  logic             neg;
  logic [IT_W-1:0]  iter;
  logic [31:0]      mean;
  logic [PW-1:0]    pt_idx;
  logic [CW-1:0]    pt_left;

  logic             accept;
  logic             full;
  logic             out_load;
  logic [CW:0]      rem_sh;
  logic [CW:0]      rem_diff;
  logic [SUM_W-1:0] quot_s;
  logic [CW-1:0]    top_m1;
  logic [CW-1:0]    top_m2;
  logic [CW-1:0]    pt_next;

  assign accept      = point_valid && !point_stall;
  assign point_stall = (state != ST_IDLE);
  assign full        = (point_count == CW'(DEPTH));
  assign top_m1      = stack_top - CW'(1);
  assign top_m2      = stack_top - CW'(2);
  assign pt_next     = CW'(pt_idx) + CW'(1);
  assign out_load    = (state == ST_OUT) && (!result_valid || !result_stall);

  assign {bel_sum, bel_cnt, bel_start} = blk_rd_data;

  // Block RAM ports: push of the register top on accept and at flush
  assign blk_wr_en   = (accept && !full && stack_top != '0) ||
                       (state == ST_FLUSH && stack_top != '0);
  assign blk_wr_addr = top_m1[PW-1:0];
  assign blk_wr_data = {top_sum, top_cnt, top_start};
  assign blk_rd_en   = (state == ST_RD) || (state == ST_BRD);
  assign blk_rd_addr = (state == ST_RD) ? top_m2[PW-1:0] : blk_idx;

  assign key_wr_en   = accept && !full;
  assign key_rd_addr = pt_idx;

  irp_ram #(.WIDTH(BLK_W), .DEPTH(DEPTH)) u_blk_ram (
    .clk     (clk),
    .wr_en   (blk_wr_en),
    .wr_addr (blk_wr_addr),
    .wr_data (blk_wr_data),
    .rd_en   (blk_rd_en),
    .rd_addr (blk_rd_addr),
    .rd_data (blk_rd_data)
  );

  irp_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (point_count[PW-1:0]),
    .wr_data (key),
    .rd_en   (state == ST_KRD),
    .rd_addr (key_rd_addr),
    .rd_data (key_rd_data)
  );

  // Restoring divide step
  assign rem_sh   = {rem[CW-1:0], dvd[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign quot_s   = neg ? (~dvd + SUM_W'(1)) : dvd;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
      stack_top   <= '0;
      overflowed  <= 1'b0;
      final_pend  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            final_pend <= final_req;
            if (full) begin
              overflowed <= 1'b1;
              state      <= final_req ? ST_FLUSH : ST_IDLE;
            end else begin
              top_sum     <= SUM_W'(sample);
              top_cnt     <= CW'(1);
              top_start   <= point_count[PW-1:0];
              point_count <= point_count + CW'(1);
              stack_top   <= stack_top + CW'(1);
              if (stack_top != '0) begin
                state <= ST_RD;
              end else begin
                state <= final_req ? ST_FLUSH : ST_IDLE;
              end
            end
          end
        end
        ST_RD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          lhs   <= top_sum * $signed({1'b0, bel_cnt});
          rhs   <= bel_sum * $signed({1'b0, top_cnt});
          state <= ST_DEC;
        end
        ST_DEC: begin
          if (lhs < rhs) begin
            top_sum   <= top_sum + bel_sum;
            top_cnt   <= top_cnt + bel_cnt;
            top_start <= bel_start;
            stack_top <= top_m1;
            if (top_m1 >= CW'(2)) begin
              state <= ST_RD;
            end else begin
              state <= final_pend ? ST_FLUSH : ST_IDLE;
            end
          end else begin
            state <= final_pend ? ST_FLUSH : ST_IDLE;
          end
        end
        ST_FLUSH: begin
          blk_idx <= '0;
          if (stack_top == '0) begin
            point_count <= '0;
            overflowed  <= 1'b0;
            state       <= ST_IDLE;
          end else begin
            state <= ST_BRD;
          end
        end
        ST_BRD: begin
          state <= ST_BLD;
        end
        ST_BLD: begin
          neg     <= bel_sum[SUM_W-1];
          dvd     <= bel_sum[SUM_W-1] ? (~bel_sum + SUM_W'(1)) : bel_sum;
          dvs     <= bel_cnt;
          rem     <= '0;
          iter    <= '0;
          pt_idx  <= bel_start;
          pt_left <= bel_cnt;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (iter == IT_W'(SUM_W)) begin
            mean  <= quot_s[31:0];
            state <= ST_KRD;
          end else begin
            iter <= iter + IT_W'(1);
            if (!rem_diff[CW]) begin
              rem <= rem_diff;
              dvd <= {dvd[SUM_W-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              dvd <= {dvd[SUM_W-2:0], 1'b0};
            end
          end
        end
        ST_KRD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            pt_idx  <= pt_next[PW-1:0];
            pt_left <= pt_left - CW'(1);
            if (pt_left == CW'(1)) begin
              if (CW'(blk_idx) + CW'(1) == stack_top) begin
                point_count <= '0;
                stack_top   <= '0;
                overflowed  <= 1'b0;
                state       <= ST_IDLE;
              end else begin
                blk_idx <= blk_idx + PW'(1);
                state   <= ST_BRD;
              end
            end else begin
              state <= ST_KRD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      key_out   <= key_rd_data;
      fitted    <= mean;
      run_end   <= (pt_next == point_count);
      truncated <= overflowed;
    end
  end

endmodule

// File: bench/tb_isotonic_regression_pava_core.sv
// Self-checking bench for isotonic_regression_pava_core: drives point data sets,
// predicts pooled block means in SV and checks every result. Depends on irp_pkg and the core.
`timescale 1ns / 1ps
module tb_isotonic_regression_pava_core;
  import irp_pkg::*;

  localparam int DEPTH = 64;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic signed [KEY_W-1:0]    key_out;
    logic signed [SAMPLE_W-1:0] fitted;
    logic                       run_end;
    logic                       truncated;
  } fit_t;

  logic clk, rst;
  logic point_valid, point_stall;
  logic signed [KEY_W-1:0] key;
  logic signed [SAMPLE_W-1:0] sample;
  logic final_req;
  logic result_valid, result_stall;
  logic signed [KEY_W-1:0] key_out;
  logic signed [SAMPLE_W-1:0] fitted;
  logic run_end, truncated;

  isotonic_regression_pava_core #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall),
    .key(key), .sample(sample), .final_req(final_req),
    .result_valid(result_valid), .result_stall(result_stall),
    .key_out(key_out), .fitted(fitted), .run_end(run_end), .truncated(truncated)
  );

  // Pooling stack mirrored in the bench
  logic [KEY_W-1:0] pt_key [DEPTH];
  longint pool_sum [DEPTH];
  int pool_cnt [DEPTH];
  int pool_first [DEPTH];
  int pts_held, pools_held;
  bit pts_dropped;

  fit_t fit_q [$];
  int errors, points_sent, fits_seen, runs_sent, clipped_runs;
  int stall_pct;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_isotonic_regression_pava_core failed");
    $finish;
  end

  // Push one point, pool violators, and on the last point emit the fitted run
  function automatic void pool_point(logic [31:0] k, logic [31:0] s, bit fin);
    int t, b, p;
    longint mean;
    fit_t f;
    if (pts_held < DEPTH) begin
      pt_key[pts_held] = k;
      pool_sum[pools_held] = longint'($signed(s));
      pool_cnt[pools_held] = 1;
      pool_first[pools_held] = pts_held;
      pools_held++;
      pts_held++;
      while (pools_held >= 2) begin
        t = pools_held - 1;
        b = pools_held - 2;
        if (!(pool_sum[t] * pool_cnt[b] < pool_sum[b] * pool_cnt[t])) break;
        pool_sum[b] += pool_sum[t];
        pool_cnt[b] += pool_cnt[t];
        pools_held--;
      end
    end else begin
      pts_dropped = 1'b1;
    end
    if (!fin) return;
    runs_sent++;
    if (pts_dropped) clipped_runs++;
    for (b = 0; b < pools_held; b++) begin
      mean = pool_sum[b] / pool_cnt[b];  // truncates toward zero
      for (p = pool_first[b]; p < pool_first[b] + pool_cnt[b]; p++) begin
        f.key_out = pt_key[p];
        f.fitted = mean[31:0];
        f.run_end = (p + 1 == pts_held);
        f.truncated = pts_dropped;
        fit_q.insert(fit_q.size(), f);
      end
    end
    pts_held = 0;
    pools_held = 0;
    pts_dropped = 1'b0;
  endfunction

  // Result side: stall pattern and checking
  always @(posedge clk) begin
    fit_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        fits_seen++;
        if (fit_q.size() == 0) begin
          $error("unexpected result key_out=%0h fitted=%0h", key_out, fitted);
          errors++;
        end else begin
          want = fit_q.pop_front();
          if (key_out !== want.key_out) begin
            $error("key_out: expected %0h got %0h", want.key_out, key_out);
            errors++;
          end
          if (fitted !== want.fitted) begin
            $error("fitted: expected %0h got %0h", want.fitted, fitted);
            errors++;
          end
          if (run_end !== want.run_end) begin
            $error("run_end: expected %0b got %0b", want.run_end, run_end);
            errors++;
          end
          if (truncated !== want.truncated) begin
            $error("truncated: expected %0b got %0b", want.truncated, truncated);
            errors++;
          end
        end
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Send one request; requests come in bursts separated by random gaps
  task automatic send_point(input logic [31:0] k, input logic [31:0] s, input bit fin);
    int gap;
    point_valid <= 1'b1;
    key <= k;
    sample <= s;
    final_req <= fin;
    do @(posedge clk); while (point_stall);
    pool_point(k, s, fin);
    points_sent++;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      burst_left = $urandom_range(12);
      gap = $urandom_range(6);
    end
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every expected result is back
  task automatic drain;
    point_valid <= 1'b0;
    while (fit_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes;
    send_point(32'h7fffffff, 32'h7fffffff, 1'b1);  // single point run
    send_point(32'h80000000, 32'h80000000, 1'b1);
    send_point(32'h0, 32'h7fffffff, 1'b0);
    send_point(32'hffffffff, 32'h7fffffff, 1'b0);
    send_point(32'h1, 32'h80000000, 1'b1);         // deep pool of extremes
  endtask

  task automatic test_shapes;
    int i;
    // ascending: no pooling
    for (i = 0; i < 5; i++) send_point(i, i * 32'h10000, i == 4);
    // descending: everything pools
    for (i = 0; i < 5; i++) send_point(100 + i, 32'h50000 - i * 32'h10000, i == 4);
    // negative mean truncates toward zero: (-1 + -2)/2 = -1
    send_point(7, -1, 1'b0);
    send_point(8, -2, 1'b0);
    send_point(9, 32'h7fffffff, 1'b1);
    // ties do not pool, then a positive odd mean
    send_point(10, 5, 1'b0);
    send_point(11, 5, 1'b0);
    send_point(12, 3, 1'b0);
    send_point(13, 2, 1'b1);
  endtask

  // Store full: extra points dropped, last one also dropped but closes the run
  task automatic test_overflow;
    int i;
    for (i = 0; i < DEPTH + 3; i++)
      send_point($urandom, $urandom_range(32'h3ffff), i == DEPTH + 2);
  endtask

  task automatic test_pause;
    send_point(1, 32'h30000, 1'b0);
    send_point(2, 32'h10000, 1'b1);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_random(input int n_items);
    int sent, len, i, style;
    logic [31:0] s, base;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 10);
      style = $urandom_range(3);
      base = $urandom;
      for (i = 0; i < len; i++) begin
        case (style)
          0: s = $urandom;                                    // full range noise
          1: s = base - i * $urandom_range(32'h20000);        // falling trend
          2: s = $urandom_range(32'h40000) - 32'h20000;       // small, mixed sign
          default: s = (i % 2) ? base : ~base;                // alternating
        endcase
        send_point($urandom, s, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    rst = 1'b1;
    point_valid = 1'b0;
    key = '0;
    sample = '0;
    final_req = 1'b0;
    errors = 0;
    points_sent = 0;
    fits_seen = 0;
    runs_sent = 0;
    clipped_runs = 0;
    stall_pct = 0;
    burst_left = 0;
    pts_held = 0;
    pools_held = 0;
    pts_dropped = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    stall_pct = 30;
    test_shapes();
    test_pause();
    stall_pct = 60;
    test_overflow();
    stall_pct = 0;
    test_random(10);
    stall_pct = 40;
    test_random(20);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d points in %0d runs (%0d truncated); checked %0d results.",
             points_sent, runs_sent, clipped_runs, fits_seen);
    if (errors == 0 && fit_q.size() == 0)
      $display("tb_isotonic_regression_pava_core passed");
    else
      $display("tb_isotonic_regression_pava_core failed");
    $finish;
  end

endmodule

// File: filelist.f
src/irp_pkg.sv
src/irp_ram.sv
src/isotonic_regression_pava_core.sv
bench/tb_isotonic_regression_pava_core.sv
